// ----- design/lbp_pkg.sv -----
// Package with the shared types and constants of the LSB-first bit packer.
package lbp_pkg;

	localparam int BYTE_W    = 8;
	localparam int SRC_W     = 64;
	localparam int OFF_W     = 3;
	localparam int CNT_W     = 6;
	localparam int PEND_W    = 7;
	localparam int MAX_APPEND = 56;
	localparam int MAX_BYTES = 7;
	localparam int NB_W      = 3;
	localparam int BUF_W     = MAX_BYTES * BYTE_W;
	localparam int ACC_W     = PEND_W + MAX_APPEND;

	typedef enum logic [0:0] {
		OP_APPEND = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

endpackage

// ----- design/lsb_first_bit_packer_unit.sv -----
// Top level of the LSB-first variable-length bit packer.
//
// The request channel (req_valid, req_stall) takes one beat per item: an
// append of bit_count bits (at most 56) of source_bits from start_offset
// upward, or a flush of the partial byte. The response channel (rsp_valid,
// rsp_stall) gives the packed bytes one beat each, first bit in bit 0, with
// last_of_run set on the last byte of an item. An item that completes no
// byte gives no beat. An accepted item is held in the input register, is then
// folded into the pending bits and loaded into the byte buffer, and its first
// byte then stands in the output register. The buffer drains one byte per
// cycle while the receiver does not stall, and an item yields zero to seven
// bytes. The next item loads into the buffer in the same cycle its last byte
// leaves.
// Reset clears the pending bits, the buffer and both valid flags. When the
// receiver stalls, the output register holds its beat, the buffer stops
// draining, and req_stall rises once the input register is full and the
// buffer still holds bytes.
module lsb_first_bit_packer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  lbp_pkg::op_t                operation,
	input  logic [lbp_pkg::SRC_W-1:0]   source_bits,
	input  logic [lbp_pkg::OFF_W-1:0]   start_offset,
	input  logic [lbp_pkg::CNT_W-1:0]   bit_count,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [lbp_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last_of_run
);
	import lbp_pkg::*;

	logic              valid_s1;
	op_t               op_s1;
	logic [SRC_W-1:0]  src_s1;
	logic [OFF_W-1:0]  off_s1;
	logic [CNT_W-1:0]  cnt_s1;

	logic [PEND_W-1:0] pend_bits_q;
	logic [NB_W-1:0]   pend_cnt_q;
	logic [BUF_W-1:0]  buf_q;
	logic [NB_W-1:0]   rem_q;
	logic              rsp_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;

	logic [CNT_W-1:0]  cnt_sat;
	logic [SRC_W-1:0]  shifted;
	logic [SRC_W-1:0]  mask;
	logic [MAX_APPEND-1:0] taken;
	logic [ACC_W-1:0]  acc;
	logic [CNT_W-1:0]  total;
	logic [NB_W-1:0]   nbytes;
	logic [NB_W-1:0]   pend_cnt_next;
	logic [PEND_W-1:0] pend_bits_next;
	logic [ACC_W-1:0]  acc_rest;
	logic              out_take;
	logic              load_ok;
	logic              load;

	always_comb begin
		cnt_sat  = (cnt_s1 > CNT_W'(MAX_APPEND)) ? CNT_W'(MAX_APPEND) : cnt_s1;
		shifted  = src_s1 >> off_s1;
		mask     = (SRC_W'(1) << cnt_sat) - SRC_W'(1);
		taken    = shifted[MAX_APPEND-1:0] & mask[MAX_APPEND-1:0];
		acc      = ACC_W'(pend_bits_q);
		nbytes   = '0;
		pend_cnt_next  = '0;
		pend_bits_next = '0;
		total    = '0;
		acc_rest = '0;
		unique case (op_s1)
			OP_FLUSH: begin
				nbytes = (pend_cnt_q != '0) ? NB_W'(1) : '0;
			end
			OP_APPEND: begin
				acc      = ACC_W'(pend_bits_q) | (ACC_W'(taken) << pend_cnt_q);
				total    = CNT_W'(pend_cnt_q) + cnt_sat;
				nbytes   = total[CNT_W-1:3];
				pend_cnt_next = total[2:0];
				acc_rest = acc >> {nbytes, 3'b000};
				pend_bits_next = acc_rest[PEND_W-1:0];
			end
			default: begin
				nbytes = '0;
			end
		endcase
	end

	assign out_take  = (rem_q != '0) && (!rsp_valid_q || !rsp_stall);
	assign load_ok   = (rem_q == '0) || ((rem_q == NB_W'(1)) && out_take);
	assign load      = valid_s1 && load_ok;
	assign req_stall = valid_s1 && !load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1  <= operation;
			src_s1 <= source_bits;
			off_s1 <= start_offset;
			cnt_s1 <= bit_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			rem_q       <= '0;
			buf_q       <= '0;
		end else begin
			if (load) begin
				pend_bits_q <= pend_bits_next;
				pend_cnt_q  <= pend_cnt_next;
				buf_q       <= acc[BUF_W-1:0];
				rem_q       <= nbytes;
			end else if (out_take) begin
				buf_q <= buf_q >> BYTE_W;
				rem_q <= rem_q - NB_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			out_byte_q <= buf_q[BYTE_W-1:0];
			last_q     <= (rem_q == NB_W'(1));
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	// With a zero pending count, the pending bits are always zero.
	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_cnt_q == '0) |-> (pend_bits_q == '0))
		else $error("pending bits set with zero pending count");

	// A byte that is not the last of its item always has more bytes behind it.
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !last_q) |-> (rem_q != '0))
		else $error("non-final byte with an empty buffer");

	// A flush that leaves the input register clears the pending bits.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (op_s1 == OP_FLUSH)) |=> (pend_cnt_q == '0))
		else $error("flush left pending bits");

endmodule
